FILE: hw/rtl/bsa_pkg.sv
// Shared types, codes and helpers for the bitmap slot allocator.
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;
   localparam int QUOT_BITS  = 9;   // slot_count width, bounds any slot quotient
   localparam int NW_W       = 10;  // width for word counts and word bases

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;

   localparam logic [1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [1:0] CSR_OBJECT_SIZE = 2'd1;
   localparam logic [1:0] CSR_SLOT_COUNT  = 2'd2;

   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_INVALID    = 3'd1;
   localparam logic [2:0] STS_EXHAUSTED  = 3'd2;
   localparam logic [2:0] STS_RANGE      = 3'd3;
   localparam logic [2:0] STS_MISALIGNED = 3'd4;
   localparam logic [2:0] STS_DOUBLE     = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_TEST,
      ST_ALLOC_MUL,
      ST_ALLOC_ADD,
      ST_DIV_WAIT,
      ST_FREE_RD,
      ST_FREE_TEST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 done;
      logic                 rem_zero;
      logic [QUOT_BITS-1:0] quotient;
   } div_result_type;

   typedef struct packed {
      logic       found;
      logic [4:0] pos;
   } find_type;

   // lowest set bit of a word
   function automatic find_type lowest_set(input logic [WORD_BITS-1:0] vec);
      find_type r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            r.found = 1'b1;
            r.pos   = 5'(i);
         end
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/bsa_bitmap_ram.sv
// Busy bitmap memory with per-word valid bits and a bulk clear.
`timescale 1ns / 1ps

module bsa_bitmap_ram #(
   parameter int NUM_WORDS = 8,
   parameter int ADDR_W    = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                addr,
   input  logic [bsa_pkg::WORD_BITS-1:0]    wr_data,
   input  logic                             clr_en,
   input  logic [bsa_pkg::NW_W-1:0]         clr_words,
   output logic [bsa_pkg::WORD_BITS-1:0]    rd_data
);

   logic [bsa_pkg::WORD_BITS-1:0] bitmap_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0]          valid_ff;
   logic [NUM_WORDS-1:0]          valid_in;
   logic [bsa_pkg::WORD_BITS-1:0] rd_q_ff;
   logic                          rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= bitmap_ff[addr];
      end
   end

   // a word never written since its last clear reads as all free
   always_comb begin
      valid_in = valid_ff;
      for (int w = 0; w < NUM_WORDS; w++) begin
         if (clr_en && (32'(w) < 32'(clr_words))) begin
            valid_in[w] = 1'b0;
         end
      end
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_vld_ff <= valid_ff[addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

FILE: hw/rtl/bsa_offset_div.sv
// Restoring divider: pool offset by object size, one quotient bit per cycle.
`timescale 1ns / 1ps

module bsa_offset_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             dividend,
   input  logic [15:0]             divisor,
   output bsa_pkg::div_result_type result
);

   logic [31:0]                   rem_ff, rem_in;
   logic [bsa_pkg::QUOT_BITS-1:0] quot_ff, quot_in;
   logic [15:0]                   dsr_ff, dsr_in;
   logic [3:0]                    step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [31:0]                   shifted;
   logic                          fits;

   // caller guarantees the quotient fits in QUOT_BITS
   assign shifted = 32'(dsr_ff) << step_ff;
   assign fits    = rem_ff >= shifted;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         quot_in = '0;
         dsr_in  = divisor;
         step_in = 4'(bsa_pkg::QUOT_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - shifted;
         end
         quot_in = {quot_ff[bsa_pkg::QUOT_BITS-2:0], fits};
         if (step_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done     = done_ff;
   assign result.rem_zero = (rem_ff == 32'd0);
   assign result.quotient = quot_ff;

endmodule

FILE: hw/rtl/bitmap_slot_allocator_core.sv
// Top level of the bitmap slot allocator: control sequencer and result register.
`timescale 1ns / 1ps

// Fixed-size object pool allocator with one busy bit per slot.
// Request beats arrive on req_*: tuser carries the opcode (allocate, free,
// reset all), tdata the object address used by free. Each request yields
// exactly one response beat on rsp_*: status, object address, slot index.
// The csr_* port sets pool base, object size and slot count; write it only
// while no request is in flight.
// One request is worked at a time. Each passes PREP (pool size), CHECK
//   (pool end) and DISPATCH; reset all, an invalid config or an out of range
//   free then go to DONE. allocate tests one bitmap word per SCAN_RD and
//   SCAN_TEST pass (one memory read per word) and forms the address in
//   ALLOC_MUL and ALLOC_ADD; an exhausted pool goes to DONE after its last word.
//   free waits in DIV_WAIT for the divider, then clears the busy bit in FREE_RD
//   and FREE_TEST; a misaligned address or a slot past the count ends at DIV_WAIT.
// A new request is taken as soon as the sequencer is idle, even while the
// previous response still waits in the output register; a stalled receiver
// holds the sequencer at its last step until the register frees up.
// Reset clears the configuration and marks every bitmap word free at once
// through per-word valid bits; no clearing pass is needed.
module bitmap_slot_allocator_core #(
   parameter int MAX_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] free_addr
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] status, [34:3] result_address,
                                    // [42:35] slot_index, [47:43] zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int NUM_WORDS = (MAX_SLOTS + bsa_pkg::WORD_BITS - 1) / bsa_pkg::WORD_BITS;
   localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CW        = $clog2(NUM_WORDS + 1);
   localparam int IDX_W     = WA + bsa_pkg::WORD_SHIFT;

   // configuration
   logic [31:0] pool_base_ff;
   logic [15:0] object_size_ff;
   logic [8:0]  slot_count_ff;

   // sequencer and working registers
   bsa_pkg::state_type state_ff, state_in;
   logic [1:0]         opcode_ff, opcode_in;
   logic [31:0]        addr_ff, addr_in;
   logic [24:0]        total_ff, total_in;
   logic [32:0]        end_ff, end_in;
   logic [CW-1:0]      word_ff, word_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W+15:0]  prod_ff, prod_in;
   logic [2:0]         status_ff, status_in;
   logic [31:0]        res_addr_ff, res_addr_in;
   logic [7:0]         slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_tdata_ff, rsp_tdata_in;

   // memory and divider hookup
   logic                          ram_rd_en, ram_wr_en, ram_clr_en;
   logic [WA-1:0]                 ram_addr;
   logic [bsa_pkg::WORD_BITS-1:0] ram_wr_data, ram_rd_data;
   logic                          div_start;
   bsa_pkg::div_result_type       div_res;

   // shared decode
   logic                          accept;
   logic                          cfg_ok;
   logic                          in_range;
   logic [bsa_pkg::NW_W-1:0]      words_used;
   logic [bsa_pkg::NW_W-1:0]      word_base;
   logic [bsa_pkg::NW_W-1:0]      limit;
   logic [bsa_pkg::WORD_BITS-1:0] slot_mask;
   logic [bsa_pkg::WORD_BITS-1:0] free_bits;
   bsa_pkg::find_type             hit;
   logic                          last_word;
   logic                          busy_bit;
   logic                          out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == bsa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // config is bad on zero size or count, count over capacity, or pool end at or past 4 GiB
   assign cfg_ok = (object_size_ff != 16'd0) && (slot_count_ff != 9'd0)
                   && (32'(slot_count_ff) <= 32'(MAX_SLOTS)) && !end_ff[32];
   assign in_range = (addr_ff >= pool_base_ff) && ({1'b0, addr_ff} < end_ff);

   assign words_used = (bsa_pkg::NW_W'(slot_count_ff) + 10'd31) >> bsa_pkg::WORD_SHIFT;
   assign word_base  = bsa_pkg::NW_W'(word_ff) << bsa_pkg::WORD_SHIFT;
   assign limit      = bsa_pkg::NW_W'(slot_count_ff) - word_base;
   assign slot_mask  = (limit >= 10'd32) ? '1 : ((32'd1 << limit[4:0]) - 32'd1);
   assign free_bits  = ~ram_rd_data & slot_mask;
   assign hit        = bsa_pkg::lowest_set(free_bits);
   assign last_word  = (bsa_pkg::NW_W'(word_ff) + 10'd1) >= words_used;
   assign busy_bit   = ram_rd_data[idx_ff[4:0]];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bsa_pkg::ST_PREP;
            end
         end
         bsa_pkg::ST_PREP:  state_in = bsa_pkg::ST_CHECK;
         bsa_pkg::ST_CHECK: state_in = bsa_pkg::ST_DISPATCH;
         bsa_pkg::ST_DISPATCH: begin
            if (!cfg_ok) begin
               state_in = bsa_pkg::ST_DONE;
            end else begin
               case (opcode_ff)
                  bsa_pkg::OP_ALLOC: state_in = bsa_pkg::ST_SCAN_RD;
                  bsa_pkg::OP_FREE:  state_in = in_range ? bsa_pkg::ST_DIV_WAIT
                                                         : bsa_pkg::ST_DONE;
                  default:           state_in = bsa_pkg::ST_DONE;
               endcase
            end
         end
         bsa_pkg::ST_SCAN_RD: state_in = bsa_pkg::ST_SCAN_TEST;
         bsa_pkg::ST_SCAN_TEST: begin
            if (hit.found) begin
               state_in = bsa_pkg::ST_ALLOC_MUL;
            end else if (last_word) begin
               state_in = bsa_pkg::ST_DONE;
            end else begin
               state_in = bsa_pkg::ST_SCAN_RD;
            end
         end
         bsa_pkg::ST_ALLOC_MUL: state_in = bsa_pkg::ST_ALLOC_ADD;
         bsa_pkg::ST_ALLOC_ADD: state_in = bsa_pkg::ST_DONE;
         bsa_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               if (div_res.rem_zero
                   && (div_res.quotient < bsa_pkg::QUOT_BITS'(slot_count_ff))) begin
                  state_in = bsa_pkg::ST_FREE_RD;
               end else begin
                  state_in = bsa_pkg::ST_DONE;
               end
            end
         end
         bsa_pkg::ST_FREE_RD:   state_in = bsa_pkg::ST_FREE_TEST;
         bsa_pkg::ST_FREE_TEST: state_in = bsa_pkg::ST_DONE;
         bsa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bsa_pkg::ST_IDLE;
            end
         end
         default: state_in = bsa_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      opcode_in    = opcode_ff;
      addr_in      = addr_ff;
      total_in     = total_ff;
      end_in       = end_ff;
      word_in      = word_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      status_in    = status_ff;
      res_addr_in  = res_addr_ff;
      slot_in      = slot_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_clr_en   = 1'b0;
      ram_addr     = word_ff[WA-1:0];
      ram_wr_data  = ram_rd_data;
      div_start    = 1'b0;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (accept) begin
               opcode_in = req_tuser;
               addr_in   = req_tdata;
            end
         end
         bsa_pkg::ST_PREP: begin
            total_in = 25'(object_size_ff) * 25'(slot_count_ff);
         end
         bsa_pkg::ST_CHECK: begin
            end_in = {1'b0, pool_base_ff} + 33'(total_ff);
         end
         bsa_pkg::ST_DISPATCH: begin
            status_in   = bsa_pkg::STS_OK;
            res_addr_in = '0;
            slot_in     = '0;
            word_in     = '0;
            if (!cfg_ok) begin
               status_in = bsa_pkg::STS_INVALID;
            end else begin
               case (opcode_ff)
                  bsa_pkg::OP_ALLOC: ;
                  bsa_pkg::OP_FREE: begin
                     if (in_range) begin
                        div_start = 1'b1;
                     end else begin
                        status_in = bsa_pkg::STS_RANGE;
                     end
                  end
                  bsa_pkg::OP_RESET: ram_clr_en = 1'b1;
                  default: status_in = bsa_pkg::STS_INVALID;
               endcase
            end
         end
         bsa_pkg::ST_SCAN_RD: begin
            ram_rd_en = 1'b1;
         end
         bsa_pkg::ST_SCAN_TEST: begin
            if (hit.found) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data | (32'd1 << hit.pos);
               idx_in      = {word_ff[WA-1:0], hit.pos};
            end else begin
               word_in = word_ff + CW'(1);
               if (last_word) begin
                  status_in = bsa_pkg::STS_EXHAUSTED;
               end
            end
         end
         bsa_pkg::ST_ALLOC_MUL: begin
            prod_in = (IDX_W + 16)'(idx_ff) * (IDX_W + 16)'(object_size_ff);
            slot_in = 8'(idx_ff);
         end
         bsa_pkg::ST_ALLOC_ADD: begin
            res_addr_in = pool_base_ff + 32'(prod_ff);
         end
         bsa_pkg::ST_DIV_WAIT: begin
            if (div_res.done) begin
               idx_in = IDX_W'(div_res.quotient);
               if (!div_res.rem_zero) begin
                  status_in = bsa_pkg::STS_MISALIGNED;
               end else if (div_res.quotient >= bsa_pkg::QUOT_BITS'(slot_count_ff)) begin
                  status_in = bsa_pkg::STS_RANGE;
               end
            end
         end
         bsa_pkg::ST_FREE_RD: begin
            ram_rd_en = 1'b1;
            ram_addr  = idx_ff[IDX_W-1:bsa_pkg::WORD_SHIFT];
         end
         bsa_pkg::ST_FREE_TEST: begin
            ram_addr = idx_ff[IDX_W-1:bsa_pkg::WORD_SHIFT];
            if (busy_bit) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = ram_rd_data & ~(32'd1 << idx_ff[4:0]);
               slot_in     = 8'(idx_ff);
            end else begin
               status_in = bsa_pkg::STS_DOUBLE;
            end
         end
         bsa_pkg::ST_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tdata_in = {5'd0, slot_ff, res_addr_ff, status_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      opcode_ff    <= opcode_in;
      addr_ff      <= addr_in;
      total_ff     <= total_in;
      end_ff       <= end_in;
      word_ff      <= word_in;
      idx_ff       <= idx_in;
      prod_ff      <= prod_in;
      status_ff    <= status_in;
      res_addr_ff  <= res_addr_in;
      slot_ff      <= slot_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bsa_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pool_base_ff   <= '0;
         object_size_ff <= '0;
         slot_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               bsa_pkg::CSR_POOL_BASE:   pool_base_ff   <= csr_wdata;
               bsa_pkg::CSR_OBJECT_SIZE: object_size_ff <= csr_wdata[15:0];
               bsa_pkg::CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   bsa_bitmap_ram #(
      .NUM_WORDS (NUM_WORDS),
      .ADDR_W    (WA)
   ) u_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (ram_rd_en),
      .wr_en     (ram_wr_en),
      .addr      (ram_addr),
      .wr_data   (ram_wr_data),
      .clr_en    (ram_clr_en),
      .clr_words (words_used),
      .rd_data   (ram_rd_data)
   );

   bsa_offset_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (addr_ff - pool_base_ff),
      .divisor  (object_size_ff),
      .result   (div_res)
   );

endmodule
